### hw/rtl/hrhp_pkg.sv
// Shared types and constants for the HTTP response head parser.
// Holds the parse phase codes, character codes and result codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

    localparam int PHASE_W = 5;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_VER      = 5'd0;
    localparam phase_t PH_T1       = 5'd1;
    localparam phase_t PH_T2       = 5'd2;
    localparam phase_t PH_P        = 5'd3;
    localparam phase_t PH_SLASH    = 5'd4;
    localparam phase_t PH_MAJOR    = 5'd5;
    localparam phase_t PH_DOT      = 5'd6;
    localparam phase_t PH_MINOR    = 5'd7;
    localparam phase_t PH_CODE     = 5'd8;
    localparam phase_t PH_CODE_SP  = 5'd9;
    localparam phase_t PH_MSG      = 5'd10;
    localparam phase_t PH_MSG_LF   = 5'd11;
    localparam phase_t PH_KEY      = 5'd12;
    localparam phase_t PH_DELIM    = 5'd13;
    localparam phase_t PH_VALUE    = 5'd14;
    localparam phase_t PH_LINE_LF  = 5'd15;
    localparam phase_t PH_END_LF   = 5'd16;
    localparam phase_t PH_DONE     = 5'd17;
    localparam phase_t PH_ERR      = 5'd18;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_SP    = 8'd32;
    localparam byte_t CH_CR    = 8'd13;
    localparam byte_t CH_LF    = 8'd10;
    localparam byte_t CH_TAB   = 8'd9;
    localparam byte_t CH_TILDE = 8'd126;
    localparam byte_t CH_H     = 8'h48;
    localparam byte_t CH_T     = 8'h54;
    localparam byte_t CH_P     = 8'h50;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_DOT   = 8'h2E;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_DASH  = 8'h2D;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CASE_BIT = 8'h20;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_NONE  = 3'd0;
    localparam kind_t KIND_VER   = 3'd1;
    localparam kind_t KIND_MSG   = 3'd2;
    localparam kind_t KIND_KEY   = 3'd3;
    localparam kind_t KIND_VALUE = 3'd4;

    typedef logic [2:0] event_t;
    localparam event_t EV_NONE      = 3'd0;
    localparam event_t EV_VER_DONE  = 3'd1;
    localparam event_t EV_CODE_DONE = 3'd2;
    localparam event_t EV_LINE_DONE = 3'd3;
    localparam event_t EV_HDR_DONE  = 3'd4;
    localparam event_t EV_HEAD_DONE = 3'd5;
    localparam event_t EV_ERROR     = 3'd6;

    typedef logic [1:0] prog_t;
    localparam prog_t PROG_BUSY  = 2'd0;
    localparam prog_t PROG_DONE  = 2'd1;
    localparam prog_t PROG_ERROR = 2'd2;

    function automatic logic is_dig(input byte_t c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_upper(input byte_t c);
        return c inside {[8'h41:8'h5A]};
    endfunction

    function automatic logic is_lower(input byte_t c);
        return c inside {[8'h61:8'h7A]};
    endfunction

    function automatic logic is_print(input byte_t c);
        return c inside {[CH_SP:CH_TILDE]};
    endfunction

    function automatic byte_t to_upper(input byte_t c);
        return is_lower(c) ? (c & ~CASE_BIT) : c;
    endfunction

    function automatic byte_t to_lower(input byte_t c);
        return is_upper(c) ? (c | CASE_BIT) : c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/http_response_head_parser_top.sv
// Top level of the HTTP response head parser: one byte in, one classified result out.
// Depends on hrhp_pkg for phase, character and result codes.
// The parse state and the result register update together when a byte is accepted.
// Throughput: one byte per cycle while the output is not stalled by m_tready low.
// Reset: aresetn clears the parse state to the version start and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module http_response_head_parser_top
    import hrhp_pkg::*;
#(
    parameter int MAX_CODE_DIGITS = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [0:0]  s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // char_out, event_res, major version digit,
                                        // minor version digit, status_value, progress,
                                        // zero pad
    output logic [2:0]       m_tuser    // char_kind
);

    localparam logic [1:0] MAX_DIGITS = 2'(MAX_CODE_DIGITS);

    phase_t      phase_reg, phase_next;
    logic [1:0]  dcount_reg, dcount_next;
    logic [9:0]  code_reg, code_next;
    logic [3:0]  major_reg, major_next;
    logic [3:0]  minor_reg, minor_next;
    logic        seen_reg, seen_next;

    logic        out_valid_reg;
    byte_t       char_reg, char_next;
    kind_t       kind_reg, kind_next;
    event_t      event_reg, event_next;
    prog_t       prog_reg, prog_next;

    logic        accept;
    byte_t       c;
    phase_t      ph;
    logic [1:0]  dc;
    logic [9:0]  code;
    logic [3:0]  major;
    logic [3:0]  minor;
    logic        seen;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    always_comb begin
        if (s_tuser[0]) begin
            ph    = PH_VER;
            dc    = '0;
            code  = '0;
            major = '0;
            minor = '0;
            seen  = 1'b0;
        end else begin
            ph    = phase_reg;
            dc    = dcount_reg;
            code  = code_reg;
            major = major_reg;
            minor = minor_reg;
            seen  = seen_reg;
        end

        phase_next  = ph;
        dcount_next = dc;
        code_next   = code;
        major_next  = major;
        minor_next  = minor;
        seen_next   = seen;
        char_next   = c;
        kind_next   = KIND_NONE;
        event_next  = EV_NONE;

        case (ph)
            PH_VER: begin
                if (c == CH_H) begin
                    kind_next  = KIND_VER;
                    phase_next = PH_T1;
                end else if (!(c == CH_SP || c inside {[CH_TAB:CH_CR]})) begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_T1, PH_T2, PH_P: begin
                if (to_upper(c) == ((ph == PH_P) ? CH_P : CH_T)) begin
                    char_next  = to_upper(c);
                    kind_next  = KIND_VER;
                    phase_next = phase_t'(ph + 5'd1);
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_SLASH, PH_DOT: begin
                if (c == ((ph == PH_SLASH) ? CH_SLASH : CH_DOT)) begin
                    kind_next  = KIND_VER;
                    phase_next = phase_t'(ph + 5'd1);
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_MAJOR: begin
                if (is_dig(c)) begin
                    major_next = c[3:0];
                    kind_next  = KIND_VER;
                    phase_next = PH_DOT;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_MINOR: begin
                if (is_dig(c)) begin
                    minor_next = c[3:0];
                    kind_next  = KIND_VER;
                    event_next = EV_VER_DONE;
                    phase_next = PH_CODE;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_CODE: begin
                if (is_dig(c) && dc < MAX_DIGITS) begin
                    code_next   = (code << 3) + (code << 1) + {6'd0, c[3:0]};
                    dcount_next = dc + 2'd1;
                end else if (c == CH_SP && dc != 2'd0) begin
                    event_next  = EV_CODE_DONE;
                    dcount_next = '0;
                    phase_next  = PH_CODE_SP;
                end else if (c != CH_SP) begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_CODE_SP, PH_MSG: begin
                if (ph == PH_CODE_SP && c == CH_SP) begin
                    phase_next = ph;
                end else if (c == CH_CR && seen) begin
                    phase_next = PH_MSG_LF;
                end else if (is_print(c)) begin
                    seen_next  = 1'b1;
                    kind_next  = KIND_MSG;
                    phase_next = PH_MSG;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_MSG_LF: begin
                if (c == CH_LF) begin
                    event_next = EV_LINE_DONE;
                    seen_next  = 1'b0;
                    phase_next = PH_KEY;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_KEY: begin
                if (c == CH_CR) begin
                    phase_next = PH_END_LF;
                end else if (is_dig(c) || is_upper(c) || is_lower(c) || c == CH_DASH) begin
                    char_next = to_lower(c);
                    kind_next = KIND_KEY;
                end else if (c == CH_COLON) begin
                    phase_next = PH_DELIM;
                end else if (c != CH_SP) begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_DELIM, PH_VALUE: begin
                if (ph == PH_DELIM && c == CH_SP) begin
                    phase_next = ph;
                end else if (c == CH_CR) begin
                    phase_next = PH_LINE_LF;
                end else if (is_print(c)) begin
                    kind_next  = KIND_VALUE;
                    phase_next = PH_VALUE;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_LINE_LF, PH_END_LF: begin
                if (c == CH_LF) begin
                    event_next = (ph == PH_LINE_LF) ? EV_HDR_DONE : EV_HEAD_DONE;
                    phase_next = (ph == PH_LINE_LF) ? PH_KEY : PH_DONE;
                end else begin
                    phase_next = PH_ERR;
                    event_next = EV_ERROR;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase

        if (phase_next == PH_DONE) begin
            prog_next = PROG_DONE;
        end else if (phase_next == PH_ERR) begin
            prog_next = PROG_ERROR;
        end else begin
            prog_next = PROG_BUSY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_VER;
            dcount_reg    <= '0;
            code_reg      <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                dcount_reg <= dcount_next;
                code_reg   <= code_next;
                major_reg  <= major_next;
                minor_reg  <= minor_next;
                seen_reg   <= seen_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg  <= char_next;
            kind_reg  <= kind_next;
            event_reg <= event_next;
            prog_reg  <= prog_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {1'b0, prog_reg, code_reg, minor_reg, major_reg, event_reg, char_reg};

    a_head_done_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && event_reg == EV_HEAD_DONE) |-> (prog_reg == PROG_DONE))
        else $error("head done beat without done progress");

    a_error_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && event_reg == EV_ERROR) |-> (prog_reg == PROG_ERROR))
        else $error("error beat without error progress");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_tuser[0] && phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("done state left without restart");

    a_digit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcount_reg <= MAX_DIGITS))
        else $error("status digit count beyond limit");

endmodule

`default_nettype wire
